[rtl/fpp_pkg.sv]
`timescale 1ns / 1ps

package fpp_pkg;

   localparam int NUM_BOARDS = 12;

   localparam logic [3:0] STATUS_INDEX = 4'd12;
   localparam logic [3:0] NO_SLOT      = 4'd12;
   localparam logic [3:0] RANK_USED_UP = 4'd15;
   localparam logic [3:0] FILE_MAX     = 4'd15;
   localparam logic [6:0] NO_EP_SQUARE = 7'd64;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_EIGHT = 8'h38;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_H     = 8'h68;
   localparam logic [7:0] CH_W     = 8'h77;

   localparam logic [7:0] CH_WP = 8'h50;
   localparam logic [7:0] CH_WN = 8'h4E;
   localparam logic [7:0] CH_WB = 8'h42;
   localparam logic [7:0] CH_WR = 8'h52;
   localparam logic [7:0] CH_WQ = 8'h51;
   localparam logic [7:0] CH_WK = 8'h4B;
   localparam logic [7:0] CH_BP = 8'h70;
   localparam logic [7:0] CH_BN = 8'h6E;
   localparam logic [7:0] CH_BB = 8'h62;
   localparam logic [7:0] CH_BR = 8'h72;
   localparam logic [7:0] CH_BQ = 8'h71;
   localparam logic [7:0] CH_BK = 8'h6B;

   typedef struct packed {
      logic [NUM_BOARDS-1:0][63:0] boards;
      logic [63:0]                 status;
      logic                        bad;
   } snap_type;

endpackage

[rtl/fpp_parse.sv]
`timescale 1ns / 1ps

module fpp_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic               clear,
   input  logic [7:0]         char_in,
   output fpp_pkg::snap_type  snap
);

   localparam logic [2:0] PH_PLACE = 3'd0;
   localparam logic [2:0] PH_SIDE1 = 3'd1;
   localparam logic [2:0] PH_SIDE2 = 3'd2;
   localparam logic [2:0] PH_CAST  = 3'd3;
   localparam logic [2:0] PH_EP    = 3'd4;
   localparam logic [2:0] PH_HALF  = 3'd5;
   localparam logic [2:0] PH_FULL  = 3'd6;
   localparam logic [2:0] PH_DONE  = 3'd7;

   localparam logic [3:0] HOLD_SKIP = 4'd9;
   localparam logic [3:0] NUM_START = 4'd0;
   localparam logic [3:0] NUM_DIGIT = 4'd1;
   localparam logic [3:0] NUM_STOP  = 4'd2;

   function automatic logic [3:0] piece_slot(input logic [7:0] c);
      logic [3:0] s;
      case (c)
         fpp_pkg::CH_WP: s = 4'd0;
         fpp_pkg::CH_WN: s = 4'd1;
         fpp_pkg::CH_WB: s = 4'd2;
         fpp_pkg::CH_WR: s = 4'd3;
         fpp_pkg::CH_WQ: s = 4'd4;
         fpp_pkg::CH_WK: s = 4'd5;
         fpp_pkg::CH_BP: s = 4'd6;
         fpp_pkg::CH_BN: s = 4'd7;
         fpp_pkg::CH_BB: s = 4'd8;
         fpp_pkg::CH_BR: s = 4'd9;
         fpp_pkg::CH_BQ: s = 4'd10;
         fpp_pkg::CH_BK: s = 4'd11;
         default:        s = fpp_pkg::NO_SLOT;
      endcase
      return s;
   endfunction

   function automatic logic [3:0] sat_add(input logic [3:0] f, input logic [3:0] by);
      logic [4:0] s;
      s = {1'b0, f} + {1'b0, by};
      return s[4] ? fpp_pkg::FILE_MAX : s[3:0];
   endfunction

   logic [fpp_pkg::NUM_BOARDS-1:0][63:0] boards_ff, boards_in;
   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  rank_ff, rank_in;
   logic [3:0]  file_ff, file_in;
   logic [5:0]  wk_ff, wk_in;
   logic [5:0]  bk_ff, bk_in;
   logic        side_ff, side_in;
   logic [3:0]  castle_ff, castle_in;
   logic [6:0]  ep_ff, ep_in;
   logic [3:0]  hold_ff, hold_in;
   logic [15:0] half_ff, half_in;
   logic [15:0] full_ff, full_in;
   logic        neg_ff, neg_in;
   logic        bad_ff, bad_in;

   logic [3:0]  slot;
   logic [5:0]  sq;
   logic [2:0]  ep_row;
   logic [2:0]  ep_col;
   logic [15:0] count;
   logic [15:0] mul10;
   logic [15:0] digit;
   logic [15:0] count_new;
   logic        is_digit;

   assign slot     = piece_slot(char_in);
   assign sq       = {rank_ff[2:0], file_ff[2:0]};
   assign ep_row   = char_in[2:0] - 3'd1;
   assign ep_col   = hold_ff[2:0] - 3'd1;
   assign count    = (phase_ff == PH_HALF) ? half_ff : full_ff;
   assign mul10    = {count[12:0], 3'b000} + {count[14:0], 1'b0};
   assign digit    = {12'd0, char_in[3:0]};
   assign count_new = neg_ff ? (mul10 - digit) : (mul10 + digit);
   assign is_digit = (char_in >= fpp_pkg::CH_ZERO) && (char_in <= fpp_pkg::CH_NINE);

   always_comb begin
      boards_in = boards_ff;
      phase_in  = phase_ff;
      rank_in   = rank_ff;
      file_in   = file_ff;
      wk_in     = wk_ff;
      bk_in     = bk_ff;
      side_in   = side_ff;
      castle_in = castle_ff;
      ep_in     = ep_ff;
      hold_in   = hold_ff;
      half_in   = half_ff;
      full_in   = full_ff;
      neg_in    = neg_ff;
      bad_in    = bad_ff;
      if (step) begin
         case (phase_ff)
            PH_PLACE: begin
               if (char_in == fpp_pkg::CH_SPACE) begin
                  phase_in = PH_SIDE1;
               end else if (rank_ff <= 4'd7) begin
                  if (char_in == fpp_pkg::CH_SLASH) begin
                     rank_in = (rank_ff == 4'd0) ? fpp_pkg::RANK_USED_UP : rank_ff - 4'd1;
                     file_in = 4'd0;
                  end else if (char_in inside {[fpp_pkg::CH_ONE:fpp_pkg::CH_EIGHT]}) begin
                     file_in = sat_add(file_ff, char_in[3:0]);
                  end else begin
                     if (slot == fpp_pkg::NO_SLOT) begin
                        bad_in = 1'b1;
                     end else if (file_ff <= 4'd7) begin
                        boards_in[slot] = boards_ff[slot] | (64'd1 << sq);
                        if (slot == 4'd5) begin
                           wk_in = sq;
                        end
                        if (slot == 4'd11) begin
                           bk_in = sq;
                        end
                     end
                     file_in = sat_add(file_ff, 4'd1);
                  end
               end
            end
            PH_SIDE1: begin
               side_in  = (char_in != fpp_pkg::CH_W);
               phase_in = (char_in == fpp_pkg::CH_SPACE) ? PH_CAST : PH_SIDE2;
            end
            PH_SIDE2: begin
               if (char_in == fpp_pkg::CH_SPACE) begin
                  phase_in = PH_CAST;
               end
            end
            PH_CAST: begin
               case (char_in)
                  fpp_pkg::CH_SPACE: begin
                     phase_in = PH_EP;
                     hold_in  = 4'd0;
                  end
                  fpp_pkg::CH_WK: castle_in = castle_ff | 4'b0001;
                  fpp_pkg::CH_WQ: castle_in = castle_ff | 4'b0010;
                  fpp_pkg::CH_BK: castle_in = castle_ff | 4'b0100;
                  fpp_pkg::CH_BQ: castle_in = castle_ff | 4'b1000;
                  default: ;
               endcase
            end
            PH_EP: begin
               if (char_in == fpp_pkg::CH_SPACE) begin
                  phase_in = PH_HALF;
                  hold_in  = NUM_START;
                  neg_in   = 1'b0;
               end else if (hold_ff == 4'd0) begin
                  hold_in = (char_in inside {[fpp_pkg::CH_A:fpp_pkg::CH_H]}) ?
                            char_in[3:0] : HOLD_SKIP;
               end else if (hold_ff <= 4'd8) begin
                  if (char_in inside {[fpp_pkg::CH_ONE:fpp_pkg::CH_EIGHT]}) begin
                     ep_in = {1'b0, ep_row, ep_col};
                  end
                  hold_in = HOLD_SKIP;
               end
            end
            PH_HALF, PH_FULL: begin
               if (char_in == fpp_pkg::CH_SPACE) begin
                  phase_in = phase_ff + 3'd1;
                  hold_in  = NUM_START;
                  neg_in   = 1'b0;
               end else if (hold_ff == NUM_START &&
                            (char_in == fpp_pkg::CH_MINUS || char_in == fpp_pkg::CH_PLUS)) begin
                  neg_in  = (char_in == fpp_pkg::CH_MINUS);
                  hold_in = NUM_DIGIT;
               end else if (hold_ff < NUM_STOP && is_digit) begin
                  if (phase_ff == PH_HALF) begin
                     half_in = count_new;
                  end else begin
                     full_in = count_new;
                  end
                  hold_in = NUM_DIGIT;
               end else begin
                  hold_in = NUM_STOP;
               end
            end
            PH_DONE: ;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         boards_ff <= '0;
         phase_ff  <= PH_PLACE;
         rank_ff   <= 4'd7;
         file_ff   <= 4'd0;
         wk_ff     <= 6'd0;
         bk_ff     <= 6'd0;
         side_ff   <= 1'b0;
         castle_ff <= 4'd0;
         ep_ff     <= fpp_pkg::NO_EP_SQUARE;
         hold_ff   <= 4'd0;
         half_ff   <= 16'd0;
         full_ff   <= 16'd0;
         neg_ff    <= 1'b0;
         bad_ff    <= 1'b0;
      end else begin
         boards_ff <= boards_in;
         phase_ff  <= phase_in;
         rank_ff   <= rank_in;
         file_ff   <= file_in;
         wk_ff     <= wk_in;
         bk_ff     <= bk_in;
         side_ff   <= side_in;
         castle_ff <= castle_in;
         ep_ff     <= ep_in;
         hold_ff   <= hold_in;
         half_ff   <= half_in;
         full_ff   <= full_in;
         neg_ff    <= neg_in;
         bad_ff    <= bad_in;
      end
   end

   assign snap.boards = boards_in;
   assign snap.status = {8'd0, full_in, half_in, bk_in, wk_in, ep_in, castle_in,
                         side_in | (phase_in == PH_SIDE1)};
   assign snap.bad    = bad_in;

endmodule

[rtl/fen_position_parser.sv]
`timescale 1ns / 1ps

// FEN text parser: one byte per transaction on req_, one per clock at full rate; every byte
// updates the position in the same cycle it is taken. The byte marked by req_tlast closes
// the string: the finished position is copied into an output buffer and the parser clears
// for the next string right away, so the next byte may follow in the next cycle. The buffer
// then sends thirteen rsp_ transactions, one per cycle while rsp_tready is high: boards
// 0-11 (white PNBRQK, black pnbrqk, bit = rank*8+file) and the status word 12, which alone
// carries rsp_tlast. Bytes of the next string are taken while that burst drains; if its
// final byte arrives before the burst has finished, req_tready drops after that byte until
// the last word of the burst is taken. Sustained rate: one byte per cycle, with strings of
// at least thirteen bytes never stalled by a consumer that is always ready.
module fen_position_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic        req_tlast,   // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [63:0] word_value, [64] bad_char_seen, [71:65] zero
   output logic [3:0]  rsp_tuser,   // [3:0] word_index
   output logic        rsp_tlast    // last_word
);

   fpp_pkg::snap_type snap;

   logic [fpp_pkg::NUM_BOARDS-1:0][63:0] boards_ff;
   logic [63:0] status_ff;
   logic        bad_ff;
   logic        busy_ff, busy_in;
   logic        pend_ff, pend_in;
   logic [3:0]  idx_ff, idx_in;

   logic        req_fire;
   logic        rsp_fire;
   logic        last_out;
   logic        slot_free;
   logic        load;
   logic [63:0] word_value;

   assign req_tready = !pend_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = busy_ff && rsp_tready;
   assign last_out   = (idx_ff == fpp_pkg::STATUS_INDEX);
   assign slot_free  = !busy_ff || (rsp_fire && last_out);
   assign load       = slot_free && ((req_fire && req_tlast) || pend_ff);

   fpp_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (req_fire),
      .clear   (load),
      .char_in (req_tdata),
      .snap    (snap)
   );

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      pend_in = pend_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = 4'd0;
         pend_in = 1'b0;
      end else begin
         if (rsp_fire) begin
            idx_in = idx_ff + 4'd1;
            if (last_out) begin
               busy_in = 1'b0;
               idx_in  = 4'd0;
            end
         end
         if (req_fire && req_tlast) begin
            pend_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
         idx_ff  <= 4'd0;
      end else begin
         busy_ff <= busy_in;
         pend_ff <= pend_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         boards_ff <= snap.boards;
         status_ff <= snap.status;
         bad_ff    <= snap.bad;
      end
   end

   assign word_value = (idx_ff < fpp_pkg::STATUS_INDEX) ? boards_ff[idx_ff] : status_ff;

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = {7'd0, bad_ff, word_value};
   assign rsp_tuser  = idx_ff;
   assign rsp_tlast  = last_out;

   a_pend_busy: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> busy_ff)
      else $error("finished string pending while output buffer idle");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= fpp_pkg::STATUS_INDEX)
      else $error("word index out of range");

   a_load_start: assert property (@(posedge clock) disable iff (reset)
      load |=> busy_ff && idx_ff == 4'd0)
      else $error("burst did not start at word 0");

   a_burst_end: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && last_out && !load |=> !busy_ff)
      else $error("burst did not end after status word");

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !(rsp_fire && last_out) |-> !load)
      else $error("buffer overwritten mid-burst");

endmodule
